### hw/rtl/fwst_pkg.sv
// fence wait/signal tracker: shared types, codes and default sizes
// no dependencies; used by the top level and the fence set
package fwst_pkg;

  localparam int unsigned DefQueues       = 8;
  localparam int unsigned DefQueueDepth   = 8;
  localparam int unsigned DefFenceSetSize = 16;
  localparam int unsigned MaxResults      = 58;

  localparam logic [1:0] OpWait   = 2'd0;
  localparam logic [1:0] OpSignal = 2'd1;
  localparam logic [1:0] OpExec   = 2'd2;
  localparam logic [1:0] OpQuery  = 2'd3;

  localparam logic [1:0] EvWait   = 2'd0;
  localparam logic [1:0] EvSignal = 2'd1;
  localparam logic [1:0] EvExec   = 2'd2;

  localparam logic [1:0] ErrNone      = 2'd0;
  localparam logic [1:0] ErrQueueFull = 2'd1;
  localparam logic [1:0] ErrSetFull   = 2'd2;

  localparam logic KindExec   = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] call_key;
    logic [2:0]  queue_key;
    logic [31:0] fence_key;
    logic [63:0] fence_value;
    logic [31:0] exec_tag;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] out_tag;
    logic [31:0] out_call_key;
    logic [2:0]  out_queue_key;
    logic        queue_waiting;
    logic [1:0]  error;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] fence_key;
    logic [63:0] fence_value;
    logic [31:0] call_key;
    logic [31:0] tag;
  } event_t;

  typedef struct packed {
    logic [31:0] fence_key;
    logic [63:0] fence_value;
  } fence_t;

endpackage

### hw/rtl/fence_wait_signal_tracker.sv
// fence wait/signal tracker top level: sequencer, queue pointers, output register
// depends on fwst_pkg, fwst_ram and fwst_fence_set
//
// usage: one input beat (in_valid_i/in_ready_o, fwst_pkg::item_t) is a wait,
// signal, execute or query on one command queue. it answers with zero or more
// released-executable beats followed by one status beat with last set, on
// out_valid_o/out_ready_i (fwst_pkg::result_t).
// the block takes one item at a time; in_ready_o is high only while idle.
// a query answers with its status beat alone; an execute on an idle queue
// also emits its executable. a wait, signal or execute may be queued, and a
// wait first searches the fence set. a firing signal walks all QUEUES heads
// with one compare unit, drains the events behind each matching head, inserts
// its fence into the set when no head matched and swaps the collected signals
// into firing order before firing them; every cascaded signal repeats the walk.
// the event and pending stores are rams with one read port. after reset all
// queues and the fence set are empty, no clearing pass is needed. a stalled
// receiver holds the output register, and the sequencer waits on it before
// each further beat.
module fence_wait_signal_tracker #(
  parameter int unsigned QUEUES         = fwst_pkg::DefQueues,
  parameter int unsigned QUEUE_DEPTH    = fwst_pkg::DefQueueDepth,
  parameter int unsigned FENCE_SET_SIZE = fwst_pkg::DefFenceSetSize
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fwst_pkg::item_t   in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fwst_pkg::result_t out_item_o
);

  localparam int unsigned SLOTS = QUEUES * QUEUE_DEPTH;
  localparam int unsigned QW    = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int unsigned SCW   = $clog2(QUEUES + 1);
  localparam int unsigned HW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned SPW   = $clog2(SLOTS + 1);
  localparam int unsigned IW    = (FENCE_SET_SIZE > 1) ? $clog2(FENCE_SET_SIZE) : 1;
  localparam int unsigned SIW   = $clog2(FENCE_SET_SIZE + 1);
  localparam int unsigned RW    = $clog2(fwst_pkg::MaxResults);
  localparam int unsigned EVW   = $bits(fwst_pkg::event_t);
  localparam int unsigned FW    = $bits(fwst_pkg::fence_t);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_SFIND   = 5'd1;
  localparam logic [4:0] S_PUSH    = 5'd2;
  localparam logic [4:0] S_EMIT    = 5'd3;
  localparam logic [4:0] S_STATUS  = 5'd4;
  localparam logic [4:0] S_FSTART  = 5'd5;
  localparam logic [4:0] S_SCAN    = 5'd6;
  localparam logic [4:0] S_HEAD    = 5'd7;
  localparam logic [4:0] S_DRAINRD = 5'd8;
  localparam logic [4:0] S_DRAIN   = 5'd9;
  localparam logic [4:0] S_INS     = 5'd10;
  localparam logic [4:0] S_REVINIT = 5'd11;
  localparam logic [4:0] S_REV     = 5'd12;
  localparam logic [4:0] S_REVA    = 5'd13;
  localparam logic [4:0] S_REVB    = 5'd14;
  localparam logic [4:0] S_REVC    = 5'd15;
  localparam logic [4:0] S_POP     = 5'd16;
  localparam logic [4:0] S_POPD    = 5'd17;

  logic [4:0]        state_q, state_d;
  fwst_pkg::item_t   item_q, item_d;
  logic              qok_q, qok_d;
  logic [1:0]        err_q, err_d;
  logic [RW-1:0]     res_n_q, res_n_d;
  fwst_pkg::fence_t  cur_q, cur_d;
  fwst_pkg::fence_t  tmp_q, tmp_d;
  logic [SPW-1:0]    sp_q, sp_d, base_q, base_d, lo_q, lo_d, hi_q, hi_d;
  logic              found_q, found_d;
  logic [SCW-1:0]    scan_q, scan_d;
  logic [SIW-1:0]    si_q, si_d;
  logic              hit_any_q, hit_any_d, free_ok_q, free_ok_d;
  logic [IW-1:0]     free_idx_q, free_idx_d;
  logic              out_valid_q, out_valid_d;
  fwst_pkg::result_t out_q, out_d;
  logic [HW-1:0]     head_q [QUEUES];
  logic [CW-1:0]     count_q [QUEUES];

  logic [QW-1:0]     qsel;
  logic              fire_st;
  logic [HW-1:0]     head_sel;
  logic [CW-1:0]     count_sel;
  logic              do_pop, do_push;
  logic              in_qok, in_busy, out_free;
  logic [CW:0]       pos_sum;
  logic [HW-1:0]     push_pos, pop_head;

  logic              ev_we;
  logic [SW-1:0]     ev_waddr, ev_raddr;
  fwst_pkg::event_t  ev_wdata, ev_rd;
  logic [EVW-1:0]    ev_rdata;
  logic              pd_we;
  logic [SW-1:0]     pd_waddr, pd_raddr;
  fwst_pkg::fence_t  pd_wdata, pd_rd;
  logic [FW-1:0]     pd_rdata;
  logic [SPW-1:0]    sp_m1;

  logic              set_hit, set_free, set_clr, set_ins;

  function automatic logic [SW-1:0] slot(input logic [QW-1:0] q, input logic [HW-1:0] h);
    return SW'(q) * SW'(QUEUE_DEPTH) + SW'(h);
  endfunction

  function automatic fwst_pkg::result_t mk_exec(input logic [31:0] tag,
                                                input logic [31:0] ck,
                                                input logic [2:0]  q);
    fwst_pkg::result_t r;
    r               = '0;
    r.kind          = fwst_pkg::KindExec;
    r.out_tag       = tag;
    r.out_call_key  = ck;
    r.out_queue_key = q;
    return r;
  endfunction

  fwst_ram #(.WIDTH(EVW), .DEPTH(SLOTS)) u_events (
    .clk_i   (clk_i),
    .we_i    (ev_we),
    .waddr_i (ev_waddr),
    .wdata_i (ev_wdata),
    .raddr_i (ev_raddr),
    .rdata_o (ev_rdata)
  );
  assign ev_rd = fwst_pkg::event_t'(ev_rdata);

  fwst_ram #(.WIDTH(FW), .DEPTH(SLOTS)) u_pending (
    .clk_i   (clk_i),
    .we_i    (pd_we),
    .waddr_i (pd_waddr),
    .wdata_i (pd_wdata),
    .raddr_i (pd_raddr),
    .rdata_o (pd_rdata)
  );
  assign pd_rd = fwst_pkg::fence_t'(pd_rdata);

  fwst_fence_set #(.SIZE(FENCE_SET_SIZE)) u_set (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .idx_i     (si_q[IW-1:0]),
    .cmp_i     (cur_q),
    .hit_o     (set_hit),
    .free_o    (set_free),
    .clr_i     (set_clr),
    .ins_i     (set_ins),
    .ins_idx_i (free_idx_q)
  );

  // queue pointer port: the scanned queue while firing, else the item's queue
  assign fire_st = (state_q == S_SCAN) || (state_q == S_HEAD) ||
                   (state_q == S_DRAINRD) || (state_q == S_DRAIN);
  always_comb begin
    if (state_q == S_IDLE) begin
      qsel = QW'(in_item_i.queue_key);
    end else if (fire_st) begin
      qsel = scan_q[QW-1:0];
    end else begin
      qsel = QW'(item_q.queue_key);
    end
  end
  assign head_sel  = head_q[qsel];
  assign count_sel = count_q[qsel];

  assign in_qok   = 32'(in_item_i.queue_key) < QUEUES;
  assign in_busy  = in_qok && (count_sel != '0);
  assign out_free = !out_valid_q || out_ready_i;

  assign pos_sum  = (CW + 1)'(head_sel) + (CW + 1)'(count_sel);
  assign push_pos = (pos_sum >= (CW + 1)'(QUEUE_DEPTH)) ?
                    HW'(pos_sum - (CW + 1)'(QUEUE_DEPTH)) : HW'(pos_sum);
  assign pop_head = (32'(head_sel) + 1 >= QUEUE_DEPTH) ? '0 : head_sel + HW'(1);

  assign ev_raddr = slot(qsel, head_sel);
  assign sp_m1    = sp_q - SPW'(1);

  always_comb begin
    unique case (state_q)
      S_REV:   pd_raddr = lo_q[SW-1:0];
      S_REVA:  pd_raddr = hi_q[SW-1:0];
      S_POP:   pd_raddr = sp_m1[SW-1:0];
      default: pd_raddr = lo_q[SW-1:0];
    endcase
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    qok_d       = qok_q;
    err_d       = err_q;
    res_n_d     = res_n_q;
    cur_d       = cur_q;
    tmp_d       = tmp_q;
    sp_d        = sp_q;
    base_d      = base_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    found_d     = found_q;
    scan_d      = scan_q;
    si_d        = si_q;
    hit_any_d   = hit_any_q;
    free_ok_d   = free_ok_q;
    free_idx_d  = free_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    do_pop      = 1'b0;
    do_push     = 1'b0;
    ev_we       = 1'b0;
    ev_waddr    = slot(qsel, push_pos);
    ev_wdata    = '0;
    pd_we       = 1'b0;
    pd_waddr    = sp_q[SW-1:0];
    pd_wdata    = '0;
    set_clr     = 1'b0;
    set_ins     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d            = in_item_i;
          qok_d             = in_qok;
          err_d             = fwst_pkg::ErrNone;
          res_n_d           = '0;
          cur_d.fence_key   = in_item_i.fence_key;
          cur_d.fence_value = in_item_i.fence_value;
          sp_d              = '0;
          si_d              = '0;
          case (in_item_i.operation)
            fwst_pkg::OpWait:   state_d = S_SFIND;
            fwst_pkg::OpSignal: state_d = in_busy ? S_PUSH : S_FSTART;
            fwst_pkg::OpExec:   state_d = in_busy ? S_PUSH : S_EMIT;
            default:            state_d = S_STATUS;
          endcase
        end
      end
      S_SFIND: begin
        if (32'(si_q) >= FENCE_SET_SIZE) begin
          if (!qok_q) begin
            err_d   = fwst_pkg::ErrQueueFull;
            state_d = S_STATUS;
          end else begin
            state_d = S_PUSH;
          end
        end else if (set_hit) begin
          set_clr = 1'b1;
          state_d = S_STATUS;
        end else begin
          si_d = si_q + SIW'(1);
        end
      end
      S_PUSH: begin
        if (32'(count_sel) >= QUEUE_DEPTH) begin
          err_d = fwst_pkg::ErrQueueFull;
        end else begin
          ev_we               = 1'b1;
          do_push             = 1'b1;
          ev_wdata.call_key   = item_q.call_key;
          if (item_q.operation == fwst_pkg::OpExec) begin
            ev_wdata.kind = fwst_pkg::EvExec;
            ev_wdata.tag  = item_q.exec_tag;
          end else begin
            ev_wdata.kind        = (item_q.operation == fwst_pkg::OpWait) ?
                                   fwst_pkg::EvWait : fwst_pkg::EvSignal;
            ev_wdata.fence_key   = item_q.fence_key;
            ev_wdata.fence_value = item_q.fence_value;
          end
        end
        state_d = S_STATUS;
      end
      S_EMIT: begin
        if (out_free) begin
          out_d       = mk_exec(item_q.exec_tag, item_q.call_key, item_q.queue_key);
          out_valid_d = 1'b1;
          res_n_d     = res_n_q + RW'(1);
          state_d     = S_STATUS;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          out_d               = '0;
          out_d.kind          = fwst_pkg::KindStatus;
          out_d.out_queue_key = item_q.queue_key;
          out_d.queue_waiting = qok_q && (count_sel != '0);
          out_d.error         = err_q;
          out_d.last          = 1'b1;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end
      S_FSTART: begin
        base_d  = sp_q;
        found_d = 1'b0;
        scan_d  = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (32'(scan_q) >= QUEUES) begin
          if (!found_q) begin
            si_d      = '0;
            hit_any_d = 1'b0;
            free_ok_d = 1'b0;
            state_d   = S_INS;
          end else begin
            state_d = S_REVINIT;
          end
        end else if (count_sel == '0) begin
          scan_d = scan_q + SCW'(1);
        end else begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        if (ev_rd.kind == fwst_pkg::EvWait && ev_rd.fence_key == cur_q.fence_key &&
            ev_rd.fence_value == cur_q.fence_value) begin
          found_d = 1'b1;
          do_pop  = 1'b1;
          state_d = S_DRAINRD;
        end else begin
          scan_d  = scan_q + SCW'(1);
          state_d = S_SCAN;
        end
      end
      S_DRAINRD: begin
        // head read issued here, data seen in the drain state
        if (count_sel == '0) begin
          scan_d  = scan_q + SCW'(1);
          state_d = S_SCAN;
        end else begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (ev_rd.kind == fwst_pkg::EvWait) begin
          scan_d  = scan_q + SCW'(1);
          state_d = S_SCAN;
        end else if (ev_rd.kind == fwst_pkg::EvExec) begin
          if (32'(res_n_q) >= fwst_pkg::MaxResults - 1) begin
            do_pop  = 1'b1;
            state_d = S_DRAINRD;
          end else if (out_free) begin
            out_d       = mk_exec(ev_rd.tag, ev_rd.call_key, 3'(scan_q));
            out_valid_d = 1'b1;
            res_n_d     = res_n_q + RW'(1);
            do_pop      = 1'b1;
            state_d     = S_DRAINRD;
          end
        end else begin
          if (ev_rd.kind == fwst_pkg::EvSignal && 32'(sp_q) < SLOTS) begin
            pd_we                = 1'b1;
            pd_wdata.fence_key   = ev_rd.fence_key;
            pd_wdata.fence_value = ev_rd.fence_value;
            sp_d                 = sp_q + SPW'(1);
          end
          do_pop  = 1'b1;
          state_d = S_DRAINRD;
        end
      end
      S_INS: begin
        if (32'(si_q) >= FENCE_SET_SIZE) begin
          if (!hit_any_q) begin
            if (free_ok_q) begin
              set_ins = 1'b1;
            end else begin
              err_d = fwst_pkg::ErrSetFull;
            end
          end
          state_d = S_REVINIT;
        end else begin
          if (set_hit) begin
            hit_any_d = 1'b1;
          end
          if (set_free && !free_ok_q) begin
            free_ok_d  = 1'b1;
            free_idx_d = si_q[IW-1:0];
          end
          si_d = si_q + SIW'(1);
        end
      end
      S_REVINIT: begin
        lo_d    = base_q;
        hi_d    = sp_q;
        state_d = S_REV;
      end
      S_REV: begin
        // reverse this round's collected signals so the first one fires first
        if ((SPW + 1)'(hi_q) > (SPW + 1)'(lo_q) + (SPW + 1)'(1)) begin
          hi_d    = hi_q - SPW'(1);
          state_d = S_REVA;
        end else begin
          state_d = S_POP;
        end
      end
      S_REVA: begin
        tmp_d   = pd_rd;
        state_d = S_REVB;
      end
      S_REVB: begin
        pd_we    = 1'b1;
        pd_waddr = lo_q[SW-1:0];
        pd_wdata = pd_rd;
        state_d  = S_REVC;
      end
      S_REVC: begin
        pd_we    = 1'b1;
        pd_waddr = hi_q[SW-1:0];
        pd_wdata = tmp_q;
        lo_d     = lo_q + SPW'(1);
        state_d  = S_REV;
      end
      S_POP: begin
        if (sp_q == '0) begin
          state_d = S_STATUS;
        end else begin
          sp_d    = sp_m1;
          state_d = S_POPD;
        end
      end
      S_POPD: begin
        cur_d   = pd_rd;
        state_d = S_FSTART;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      err_q       <= '0;
      res_n_q     <= '0;
      qok_q       <= 1'b0;
      sp_q        <= '0;
      base_q      <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      found_q     <= 1'b0;
      scan_q      <= '0;
      si_q        <= '0;
      hit_any_q   <= 1'b0;
      free_ok_q   <= 1'b0;
      free_idx_q  <= '0;
      for (int i = 0; i < QUEUES; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      err_q       <= err_d;
      res_n_q     <= res_n_d;
      qok_q       <= qok_d;
      sp_q        <= sp_d;
      base_q      <= base_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      found_q     <= found_d;
      scan_q      <= scan_d;
      si_q        <= si_d;
      hit_any_q   <= hit_any_d;
      free_ok_q   <= free_ok_d;
      free_idx_q  <= free_idx_d;
      if (do_pop) begin
        head_q[qsel]  <= pop_head;
        count_q[qsel] <= count_sel - CW'(1);
      end else if (do_push) begin
        count_q[qsel] <= count_sel + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    cur_q  <= cur_d;
    tmp_q  <= tmp_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### hw/rtl/fwst_ram.sv
// simple dual-port ram: one write port, one read port with registered data
// no dependencies; holds queue events and the pending signal stack
module fwst_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/fwst_fence_set.sv
// fence set: valid bits, stored (key, value) pairs and one shared compare
// depends on fwst_pkg; the sequencer walks the index one entry per cycle
module fwst_fence_set #(
  parameter int unsigned SIZE = fwst_pkg::DefFenceSetSize,
  localparam int unsigned IW  = (SIZE > 1) ? $clog2(SIZE) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [IW-1:0]   idx_i,
  input  fwst_pkg::fence_t cmp_i,
  output logic            hit_o,
  output logic            free_o,
  input  logic            clr_i,
  input  logic            ins_i,
  input  logic [IW-1:0]   ins_idx_i
);

  logic [SIZE-1:0]  valid_q;
  fwst_pkg::fence_t entry_q [SIZE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (clr_i) begin
        valid_q[idx_i] <= 1'b0;
      end
      if (ins_i) begin
        valid_q[ins_idx_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_i) begin
      entry_q[ins_idx_i] <= cmp_i;
    end
  end

  assign hit_o  = valid_q[idx_i] && (entry_q[idx_i] == cmp_i);
  assign free_o = !valid_q[idx_i];

endmodule
